// ----- hw/rtl/afr_pkg.sv -----
package afr_pkg;

    localparam int unsigned HdrBytes   = 24;
    localparam int unsigned WordW      = 32;
    localparam int unsigned MaxLenW    = 21;
    localparam int unsigned CntW       = 5;

    localparam logic [WordW-1:0]   AllOnes      = 32'hFFFF_FFFF;
    localparam logic [MaxLenW-1:0] MaxLenReset  = 21'd8192;
    localparam logic [CntW-1:0]    HdrLastCount = 5'(HdrBytes - 1);

    // header word slots
    localparam logic [2:0] W_CMD   = 3'd0;
    localparam logic [2:0] W_ARG0  = 3'd1;
    localparam logic [2:0] W_ARG1  = 3'd2;
    localparam logic [2:0] W_LEN   = 3'd3;
    localparam logic [2:0] W_SUM   = 3'd4;
    localparam logic [2:0] W_MAGIC = 3'd5;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MAGIC    = 2'd1,
        ST_LENGTH   = 2'd2,
        ST_CHECKSUM = 2'd3
    } t_status;

    typedef struct packed {
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic             frame_end;
        logic [WordW-1:0] command_word;
        logic [WordW-1:0] first_argument;
        logic [WordW-1:0] second_argument;
        logic [WordW-1:0] payload_length;
        t_status          frame_status;
    } t_result;

endpackage

// ----- hw/rtl/afr_parser.sv -----
module afr_parser (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic [7:0]                            i_rx_byte,
    input  logic                                  i_cfg_we,
    input  logic [afr_pkg::MaxLenW-1:0]           i_cfg_wdata,
    output logic                                  o_res_valid,
    output afr_pkg::t_result                      o_res
);

    logic                          r_in_payload;
    logic [afr_pkg::CntW-1:0]      r_hdr_cnt;
    logic [afr_pkg::WordW-1:0]     r_hdr_words [6];
    logic [afr_pkg::WordW-1:0]     r_remaining;
    logic [afr_pkg::WordW-1:0]     r_sum;
    logic [afr_pkg::MaxLenW-1:0]   r_max_len;

    logic                          n_in_payload;
    logic [afr_pkg::CntW-1:0]      n_hdr_cnt;
    logic [afr_pkg::WordW-1:0]     n_remaining;
    logic [afr_pkg::WordW-1:0]     n_sum;

    logic [2:0]                    w_idx;
    logic [1:0]                    w_lane;
    logic                          w_hdr_last;
    logic [afr_pkg::WordW-1:0]     w_magic;
    logic [afr_pkg::WordW-1:0]     w_sum_next;
    logic                          w_pay_last;

    assign w_idx      = r_hdr_cnt[4:2];
    assign w_lane     = r_hdr_cnt[1:0];
    assign w_hdr_last = (r_hdr_cnt == afr_pkg::HdrLastCount);
    assign w_magic    = {i_rx_byte, r_hdr_words[afr_pkg::W_MAGIC][23:0]};
    assign w_sum_next = r_sum + {24'd0, i_rx_byte};
    assign w_pay_last = (r_remaining == 32'd1);

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_cnt    = r_hdr_cnt;
        n_remaining  = r_remaining;
        n_sum        = r_sum;
        o_res_valid  = 1'b0;
        o_res        = '0;
        if (i_accept) begin
            if (r_in_payload) begin
                n_sum                = w_sum_next;
                n_remaining          = r_remaining - 32'd1;
                o_res_valid          = 1'b1;
                o_res.payload_valid  = 1'b1;
                o_res.payload_byte   = i_rx_byte;
                if (w_pay_last) begin
                    n_in_payload          = 1'b0;
                    o_res.frame_end       = 1'b1;
                    o_res.frame_status    =
                        (w_sum_next == r_hdr_words[afr_pkg::W_SUM]) ?
                        afr_pkg::ST_OK : afr_pkg::ST_CHECKSUM;
                end
            end else if (!w_hdr_last) begin
                n_hdr_cnt = r_hdr_cnt + 5'd1;
            end else begin
                n_hdr_cnt = '0;
                if ((r_hdr_words[afr_pkg::W_CMD] ^ afr_pkg::AllOnes) != w_magic) begin
                    o_res_valid        = 1'b1;
                    o_res.frame_status = afr_pkg::ST_MAGIC;
                end else if (r_hdr_words[afr_pkg::W_LEN] >
                             {11'd0, r_max_len}) begin
                    o_res_valid        = 1'b1;
                    o_res.frame_status = afr_pkg::ST_LENGTH;
                end else if (r_hdr_words[afr_pkg::W_LEN] == 32'd0) begin
                    o_res_valid        = 1'b1;
                    o_res.frame_status = afr_pkg::ST_OK;
                end else begin
                    n_in_payload = 1'b1;
                    n_remaining  = r_hdr_words[afr_pkg::W_LEN];
                    n_sum        = '0;
                end
            end
            if (o_res.frame_end || (!r_in_payload && w_hdr_last && o_res_valid)) begin
                o_res.frame_end       = 1'b1;
                o_res.command_word    = r_hdr_words[afr_pkg::W_CMD];
                o_res.first_argument  = r_hdr_words[afr_pkg::W_ARG0];
                o_res.second_argument = r_hdr_words[afr_pkg::W_ARG1];
                o_res.payload_length  = r_hdr_words[afr_pkg::W_LEN];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= '0;
            r_remaining  <= '0;
            r_sum        <= '0;
            r_max_len    <= afr_pkg::MaxLenReset;
        end else begin
            r_in_payload <= n_in_payload;
            r_hdr_cnt    <= n_hdr_cnt;
            r_remaining  <= n_remaining;
            r_sum        <= n_sum;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    // header assembly, little-endian byte lanes
    always_ff @(posedge i_clk) begin
        if (i_accept && !r_in_payload) begin
            r_hdr_words[w_idx][{w_lane, 3'b000} +: 8] <= i_rx_byte;
        end
    end

endmodule

// ----- hw/rtl/afr_out_skid.sv -----
module afr_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  afr_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output afr_pkg::t_result o_res
);

    logic             r_out_valid;
    logic             r_skid_valid;
    afr_pkg::t_result r_out;
    afr_pkg::t_result r_skid;
    logic             w_free;

    assign w_free      = !r_out_valid || !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_res;
            end
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule

// ----- hw/rtl/adb_frame_receiver_core.sv -----
// a word's result is registered into the output entry, or the skid entry on output stall
// throughput: one received word per cycle while not stalled; a two-entry output buffer
// absorbs output stalls; input stall rises only when both output entries hold results
// reset (synchronous, active low) returns to header hunt, clears counts and sum,
// empties the output buffer and sets the maximum payload length to 8192
module adb_frame_receiver_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_rx_byte,
    input  logic                        i_cfg_we,
    input  logic [afr_pkg::MaxLenW-1:0] i_cfg_wdata,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_payload_valid,
    output logic [7:0]                  o_payload_byte,
    output logic                        o_frame_end,
    output logic [31:0]                 o_command_word,
    output logic [31:0]                 o_first_argument,
    output logic [31:0]                 o_second_argument,
    output logic [31:0]                 o_payload_length,
    output logic [1:0]                  o_frame_status
);

    logic             w_accept;
    logic             w_res_valid;
    logic             w_full;
    afr_pkg::t_result w_res;
    afr_pkg::t_result w_out;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    afr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    afr_out_skid u_out_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res_valid),
        .i_res       (w_res),
        .o_full      (w_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (w_out)
    );

    assign o_payload_valid   = w_out.payload_valid;
    assign o_payload_byte    = w_out.payload_byte;
    assign o_frame_end       = w_out.frame_end;
    assign o_command_word    = w_out.command_word;
    assign o_first_argument  = w_out.first_argument;
    assign o_second_argument = w_out.second_argument;
    assign o_payload_length  = w_out.payload_length;
    assign o_frame_status    = w_out.frame_status;

`ifndef ASSERT_OFF
    a_full_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("buffer full without a pending output word");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_payload_valid || o_frame_end))
        else $error("result carries neither payload nor frame end");

    a_no_frame_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_end) |->
            (o_frame_status == afr_pkg::ST_OK && o_command_word == 32'd0))
        else $error("header fields set on a non-final word");

    a_hdr_err_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_payload_valid) |-> (o_payload_byte == 8'd0))
        else $error("payload byte set without payload valid");
`endif

endmodule
